// ===== design/acsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsq_pkg
// Shared types, codes and helpers of the ADC channel scan sequencer.
// ----------------------------------------------------------------------------
package acsq_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MASK_W           = 8;
  localparam int CH_W             = 3;
  localparam int SAMPLE_W         = 8;
  localparam int OP_W             = 2;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 8;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CONV_DONE = 2'd0,
    OP_START     = 2'd1,
    OP_STOP      = 2'd2,
    OP_READ      = 2'd3
  } acsq_op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_MASK = 1'd0,
    REG_AUTO_REPEAT  = 1'd1
  } acsq_reg_t;

  // sample store access issued by the control path
  typedef struct packed {
    logic            load;
    logic            wr_en;
    logic [CH_W-1:0] wr_ch;
    logic            rd_en;
    logic [CH_W-1:0] rd_ch;
  } acsq_mem_req_t;

  // priority encoder result
  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] ch;
  } acsq_pick_t;

  // lowest set bit of a channel mask
  function automatic acsq_pick_t pick_lowest(input logic [MASK_W-1:0] bits);
    acsq_pick_t r;
    r.found = 1'b0;
    r.ch    = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        r.found = 1'b1;
        r.ch    = CH_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/acsq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsq_store
// Per-channel sample memory with one write and one registered read port.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module acsq_store #(
  parameter int NUM_CHANNELS = acsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acsq_pkg::acsq_mem_req_t       req,
  input  logic [acsq_pkg::SAMPLE_W-1:0] wr_data,
  output logic [acsq_pkg::SAMPLE_W-1:0] rd_data
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [acsq_pkg::SAMPLE_W-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]       valid_r;
  logic [acsq_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_hit;

  assign wr_addr = AW'(req.wr_ch);
  assign rd_addr = AW'(req.rd_ch);
  // channels beyond the store read as zero
  assign rd_hit  = req.rd_en && (int'(req.rd_ch) < NUM_CHANNELS);

  // memory write
  always_ff @(posedge clk) begin
    if (req.load && req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.load && req.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read, doubles as the output data register
  always_ff @(posedge clk) begin
    if (req.load) begin
      if (rd_hit && valid_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/acsq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsq_ctrl
// Scan control: config registers, channel walk, handshake and result register.
// Issues store accesses for conversion-done and read items.
// ----------------------------------------------------------------------------
module acsq_ctrl #(
  parameter int NUM_CHANNELS = acsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acsq_pkg::OP_W-1:0]       in_operation,
  input  logic [acsq_pkg::CH_W-1:0]       in_channel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_start_conversion,
  output logic [acsq_pkg::CH_W-1:0]       out_conversion_channel,
  output logic                            out_scan_active,
  output acsq_pkg::acsq_mem_req_t         mem_req
);

  localparam int ScanLimit = (NUM_CHANNELS < acsq_pkg::MASK_W) ? NUM_CHANNELS
                                                                 : acsq_pkg::MASK_W;

  logic [acsq_pkg::MASK_W-1:0] channel_mask_r;
  logic                        auto_repeat_r;
  logic [acsq_pkg::CH_W-1:0]   cur_ch_r, cur_ch_nxt;
  logic                        active_r, active_nxt;
  logic                        stop_pend_r, stop_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_start_r;
  logic [acsq_pkg::CH_W-1:0]   out_ch_r;
  logic                        out_active_r;
  logic                        req_start;
  logic [acsq_pkg::CH_W-1:0]   req_ch;
  logic                        accept;
  logic [acsq_pkg::MASK_W-1:0] eff_mask;
  logic [acsq_pkg::MASK_W-1:0] above_mask;
  acsq_pkg::acsq_pick_t        pick_first;
  acsq_pkg::acsq_pick_t        pick_above;
  acsq_pkg::acsq_op_t          op;

  assign op       = acsq_pkg::acsq_op_t'(in_operation);
  // output register frees up when its item is taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_mask_r <= '0;
      auto_repeat_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (acsq_pkg::acsq_reg_t'(cfg_index))
        acsq_pkg::REG_CHANNEL_MASK: channel_mask_r <= cfg_wdata;
        acsq_pkg::REG_AUTO_REPEAT:  auto_repeat_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // enabled channels, and those above the current one
  always_comb begin
    for (int i = 0; i < acsq_pkg::MASK_W; i++) begin
      eff_mask[i]   = channel_mask_r[i] && (i < ScanLimit);
      above_mask[i] = eff_mask[i] && (acsq_pkg::CH_W'(i) > cur_ch_r);
    end
  end

  assign pick_first = acsq_pkg::pick_lowest(eff_mask);
  assign pick_above = acsq_pkg::pick_lowest(above_mask);

  // scan state update per item
  always_comb begin
    cur_ch_nxt    = cur_ch_r;
    active_nxt    = active_r;
    stop_pend_nxt = stop_pend_r;
    req_start     = 1'b0;
    req_ch        = '0;
    unique case (op)
      acsq_pkg::OP_CONV_DONE: begin
        if (active_r) begin
          if (stop_pend_r) begin
            active_nxt    = 1'b0;
            stop_pend_nxt = 1'b0;
          end else if (pick_above.found) begin
            cur_ch_nxt = pick_above.ch;
            req_start  = 1'b1;
            req_ch     = pick_above.ch;
          end else if (auto_repeat_r && pick_first.found) begin
            cur_ch_nxt = pick_first.ch;
            req_start  = 1'b1;
            req_ch     = pick_first.ch;
          end else begin
            active_nxt = 1'b0;
          end
        end
      end
      acsq_pkg::OP_START: begin
        if (pick_first.found) begin
          cur_ch_nxt    = pick_first.ch;
          active_nxt    = 1'b1;
          stop_pend_nxt = 1'b0;
          req_start     = 1'b1;
          req_ch        = pick_first.ch;
        end
      end
      acsq_pkg::OP_STOP: begin
        if (active_r) begin
          stop_pend_nxt = 1'b1;
        end
      end
      acsq_pkg::OP_READ: ;
      default: ;
    endcase
  end

  // store access for this item
  always_comb begin
    mem_req.load  = accept;
    mem_req.wr_en = (op == acsq_pkg::OP_CONV_DONE) && active_r;
    mem_req.wr_ch = cur_ch_r;
    mem_req.rd_en = (op == acsq_pkg::OP_READ);
    mem_req.rd_ch = in_channel;
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_ch_r    <= '0;
      active_r    <= 1'b0;
      stop_pend_r <= 1'b0;
    end else if (accept) begin
      cur_ch_r    <= cur_ch_nxt;
      active_r    <= active_nxt;
      stop_pend_r <= stop_pend_nxt;
    end
  end

  // result register
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_start_r  <= req_start;
      out_ch_r     <= req_ch;
      out_active_r <= active_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_start_conversion   = out_start_r;
  assign out_conversion_channel = out_ch_r;
  assign out_scan_active        = out_active_r;

endmodule

// ===== design/adc_channel_scan_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_core
// Steps an ADC through the channels enabled in a mask and keeps the last
// sample of each channel for read-back.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle and its result appears in the output
// register on the next cycle; a waiting result does not block the next item
// unless out_stall is high. The per-channel sample store is a one-write,
// one-read memory with registered read data; a read item sees every sample
// written by earlier items, since the write lands at the accepting edge of the
// conversion-done item. The next-channel search is a pair of priority encoders
// over the mask, so the search is combinational. Configuration writes
// take effect on the next item and should be made while no item is in flight.
module adc_channel_scan_sequencer_core #(
  parameter int NUM_CHANNELS = acsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acsq_pkg::OP_W-1:0]       in_operation,
  input  logic [acsq_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic [acsq_pkg::CH_W-1:0]       in_channel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_start_conversion,
  output logic [acsq_pkg::CH_W-1:0]       out_conversion_channel,
  output logic [acsq_pkg::SAMPLE_W-1:0]   out_read_data,
  output logic                            out_scan_active
);

  acsq_pkg::acsq_mem_req_t mem_req;

  // scan control and result register
  acsq_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_channel            (in_channel),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_start_conversion  (out_start_conversion),
    .out_conversion_channel(out_conversion_channel),
    .out_scan_active       (out_scan_active),
    .mem_req               (mem_req)
  );

  // sample store
  acsq_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mem_req),
    .wr_data(in_sample),
    .rd_data(out_read_data)
  );

endmodule

// ===== design/acsq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsq_checker
// Port-level checks of the scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module acsq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [acsq_pkg::OP_W-1:0]       in_operation,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_start_conversion,
  input logic [acsq_pkg::CH_W-1:0]       out_conversion_channel,
  input logic [acsq_pkg::SAMPLE_W-1:0]   out_read_data,
  input logic                            out_scan_active
);

  // no result is left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_start_conversion)
      && $stable(out_conversion_channel) && $stable(out_read_data)
      && $stable(out_scan_active))
    else $error("stalled result changed");

  // a conversion request always leaves the scan running
  a_req_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_conversion |-> out_scan_active)
    else $error("conversion requested with scan idle");

  // channel is zero when nothing is requested
  a_ch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_start_conversion |-> out_conversion_channel == '0)
    else $error("channel set without a request");

  // only read items return data
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation != acsq_pkg::OP_READ)
      |=> out_read_data == '0)
    else $error("read data on a non-read item");

endmodule

bind adc_channel_scan_sequencer_core acsq_checker u_acsq_checker (.*);
